// ===== hdl/htsp_pkg.sv =====
// Shared constants, types and the CRC-8 helper for the humidity/temperature poller.
`default_nettype none

package htsp_pkg;

    // Stream widths in bits.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Sensor command bytes.
    localparam logic [7:0] CMD_TEMPERATURE = 8'hF3;
    localparam logic [7:0] CMD_HUMIDITY    = 8'hF5;
    localparam logic [7:0] CMD_NONE        = 8'h00;

    // CRC-8 polynomial, zero initial value, no final XOR.
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Humidity readings carry a status bit that is flipped before scaling.
    localparam logic [15:0] HUM_XOR_MASK = 16'h0002;

    // Fixed-point scale factors (value = (k * raw + half) >> 16 - offset).
    localparam logic [14:0] TEMP_SCALE  = 15'd17572;
    localparam logic [14:0] HUM_SCALE   = 15'd12500;
    localparam logic [30:0] ROUND_HALF  = 31'h0000_8000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4685;
    localparam logic [15:0] HUM_OFFSET  = 16'd600;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_POLLING = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BADCRC  = 2'd3;

    // Action codes carried on the input tuser.
    localparam logic ACT_REQUEST  = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;

    // One result item.
    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        command;
        logic              is_temperature;
        logic signed [14:0] value;
    } htsp_result_t;

    // One CRC-8 byte update, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/humidity_temp_sensor_poller.sv =====
// Top level of the alternating humidity/temperature sensor poller.
//
// Usage: the input stream carries one beat per poll event. tuser says whether
// the beat is a measurement request (0) or a received response (1); tdata holds
// the bus success flag and the three sensor bytes. Every input beat produces
// exactly one output beat with a status code, the command byte to send on a
// request, the phase the beat belonged to (tuser) and the converted reading in
// hundredths of a degree C or a percent RH.
// Registers: an accepted input beat passes the input register, then the
// result register. Throughput: one beat per cycle unless the receiver stalls;
// the CRC check and the single constant multiply sit between the registers.
// The phase starts at humidity after reset and toggles only on a response
// whose CRC matches. Reset empties both registers.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; further input waits until the output
// drains.
`default_nettype none

module humidity_temp_sensor_poller #(
    parameter int IN_DATA_W  = htsp_pkg::IN_DATA_W,
    parameter int OUT_DATA_W = htsp_pkg::OUT_DATA_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: bus_ok, msb, lsb, crc_byte (from bit 0 up), zero padded.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action.
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: status, command, value (from bit 0 up), zero padded.
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: is_temperature.
    output logic                       m_axis_tuser
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic                   in_user_reg;
    logic [24:0]            in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    htsp_pkg::htsp_result_t res_reg;
    htsp_pkg::htsp_result_t res_next;
    logic                   phase_reg;
    logic                   phase_next;
    logic                   toggle;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // Handshake: the result register takes a beat when it is empty or draining.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);
    assign phase_next     = (advance && toggle) ? !phase_reg : phase_reg;

    // Conversion logic between the two registers.
    htsp_core u_core (
        .phase    (phase_reg),
        .action   (in_user_reg),
        .bus_ok   (in_data_reg[0]),
        .msb      (in_data_reg[8:1]),
        .lsb      (in_data_reg[16:9]),
        .crc_byte (in_data_reg[24:17]),
        .result   (res_next),
        .toggle   (toggle)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_user_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[24:0];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.is_temperature;
    assign m_axis_tdata  = {{(OUT_DATA_W - 25){1'b0}}, res_reg.value,
                            res_reg.command, res_reg.status};

    // A polling result always carries the command of its own phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.status == htsp_pkg::ST_POLLING) |->
        (res_reg.command == (res_reg.is_temperature ? htsp_pkg::CMD_TEMPERATURE
                                                    : htsp_pkg::CMD_HUMIDITY)))
        else $error("polling result with wrong command");

    // Response results never carry a command byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (res_reg.status == htsp_pkg::ST_OK ||
                           res_reg.status == htsp_pkg::ST_BADCRC)) |->
        (res_reg.command == htsp_pkg::CMD_NONE))
        else $error("response result with a command byte");

    // The phase only flips together with an ok result of the old phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |->
        (out_valid_reg && res_reg.status == htsp_pkg::ST_OK &&
         res_reg.is_temperature == $past(phase_reg)))
        else $error("phase changed without a good reading");

    // A nonzero value only comes with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.value != 15'sd0) |->
        (res_reg.status == htsp_pkg::ST_OK))
        else $error("value on a non-ok result");

endmodule

`default_nettype wire

// ===== hdl/htsp_core.sv =====
// Combinational CRC check and fixed-point conversion for one registered item.
`default_nettype none

module htsp_core (
    input  wire logic                  phase,
    input  wire logic                  action,
    input  wire logic                  bus_ok,
    input  wire logic [7:0]            msb,
    input  wire logic [7:0]            lsb,
    input  wire logic [7:0]            crc_byte,
    output htsp_pkg::htsp_result_t     result,
    output logic                       toggle
);

    logic [7:0]         crc_calc;
    logic [15:0]        raw;
    logic [15:0]        x;
    logic [14:0]        scale;
    logic [15:0]        offset;
    logic [30:0]        prod;
    logic [30:0]        rounded;
    logic [14:0]        scaled;
    logic signed [15:0] conv;

    // CRC over the two reading bytes.
    assign crc_calc = htsp_pkg::crc8_byte(htsp_pkg::crc8_byte(8'h00, msb), lsb);
    assign raw      = {msb, lsb};

    // One shared constant multiply; the phase picks scale, offset and input.
    assign x      = phase ? raw : (raw ^ htsp_pkg::HUM_XOR_MASK);
    assign scale  = phase ? htsp_pkg::TEMP_SCALE : htsp_pkg::HUM_SCALE;
    assign offset = phase ? htsp_pkg::TEMP_OFFSET : htsp_pkg::HUM_OFFSET;

    assign prod    = {16'd0, scale} * {15'd0, x};
    assign rounded = prod + htsp_pkg::ROUND_HALF;
    assign scaled  = rounded[30:16];
    assign conv    = $signed({1'b0, scaled}) - $signed(offset);

    // Status, command and phase update.
    always_comb
    begin
        result.is_temperature = phase;
        result.command        = htsp_pkg::CMD_NONE;
        result.value          = '0;
        toggle                = 1'b0;
        if (action == htsp_pkg::ACT_REQUEST)
        begin
            result.command = phase ? htsp_pkg::CMD_TEMPERATURE : htsp_pkg::CMD_HUMIDITY;
            result.status  = bus_ok ? htsp_pkg::ST_POLLING : htsp_pkg::ST_TIMEOUT;
        end
        else if (!bus_ok)
        begin
            result.status = htsp_pkg::ST_TIMEOUT;
        end
        else if (crc_calc != crc_byte)
        begin
            result.status = htsp_pkg::ST_BADCRC;
        end
        else
        begin
            result.status = htsp_pkg::ST_OK;
            result.value  = conv[14:0];
            toggle        = 1'b1;
        end
    end

endmodule

`default_nettype wire
